// ===== sv/wwsf_pkg.sv =====
// ----------------------------------------------------------------------------
// wwsf_pkg
// Shared types, constants and byte helpers for the whole-word substring finder.
// ----------------------------------------------------------------------------
package wwsf_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int LINE_MAX_DEFAULT    = 4096;

   localparam int REG_BYTES = 16;   // bytes held by the two pattern registers
   localparam int LEN_W     = 5;    // pattern_length width
   localparam int OFFSET_W  = 12;   // match_offset width
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int Q_DEPTH   = 4;    // result queue entries

   localparam logic [7:0] LETTER_ABOVE = 8'h80;
   localparam logic [7:0] UNDERSCORE   = 8'h5F;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_CASE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WHOLE_WORD     = 3'd4;

   // settings every cell of the window needs
   typedef struct packed {
      logic [REG_BYTES*8-1:0] pattern;   // byte i at bits [8i+7:8i]
      logic [LEN_W-1:0]       length;    // active length, already clamped
      logic                   exact;     // 1: no case folding
   } cell_cfg_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic                last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } push_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
      logic [7:0] r;
      r = c;
      if (!exact && (c inside {[8'h41:8'h5A]})) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic letter(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], UNDERSCORE}) || (c > LETTER_ABOVE);
   endfunction

endpackage

// ===== sv/wwsf_cell.sv =====
// ----------------------------------------------------------------------------
// wwsf_cell
// One window cell: holds one text byte, passes it on each beat, and compares
// the byte arriving in it against its pattern byte.
// ----------------------------------------------------------------------------
module wwsf_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  shift,
   input  wwsf_pkg::cell_cfg_type cfg,
   input  logic [7:0]            byte_in,
   output logic [7:0]            byte_q,
   output logic                  match
);

   logic [7:0] byte_ff;
   logic [3:0] pat_idx;
   logic [7:0] pat_byte;
   logic       in_use;

   // cell k sees the byte k places back from the newest, which lines up
   // with pattern byte (length - 1 - k)
   always_comb begin
      in_use   = wwsf_pkg::LEN_W'(INDEX) < cfg.length;
      pat_idx  = 4'(cfg.length - wwsf_pkg::LEN_W'(INDEX) - wwsf_pkg::LEN_W'(1));
      pat_byte = cfg.pattern[pat_idx*8 +: 8];
      match    = !in_use ||
                 (wwsf_pkg::fold(byte_in, cfg.exact) ==
                  wwsf_pkg::fold(pat_byte, cfg.exact));
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_q = byte_ff;

endmodule

// ===== sv/wwsf_queue.sv =====
// ----------------------------------------------------------------------------
// wwsf_queue
// Small result queue: takes up to two results a cycle, hands out one a beat.
// ----------------------------------------------------------------------------
module wwsf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  wwsf_pkg::push_type   push0,
   input  wwsf_pkg::push_type   push1,   // only used together with push0
   output logic                 room,    // space for two more results
   output logic                 out_valid,
   input  logic                 out_ready,
   output wwsf_pkg::result_type out_data
);

   localparam int PTR_W = $clog2(wwsf_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(wwsf_pkg::Q_DEPTH + 1);

   wwsf_pkg::result_type mem_ff [wwsf_pkg::Q_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [CNT_W-1:0] pushes;

   always_comb begin
      pop      = out_valid && out_ready;
      pushes   = CNT_W'(push0.valid) + CNT_W'(push0.valid && push1.valid);
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff + PTR_W'(pushes);
      count_in = count_ff + pushes - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0.valid) begin
         mem_ff[tail_ff] <= push0.data;
         if (push1.valid) begin
            mem_ff[tail_ff + PTR_W'(1)] <= push1.data;
         end
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[head_ff];
   assign room      = count_ff <= CNT_W'(wwsf_pkg::Q_DEPTH - 2);

endmodule

// ===== sv/whole_word_substring_finder.sv =====
// ----------------------------------------------------------------------------
// whole_word_substring_finder
// Streaming search for a 1..16 byte pattern in a text line, with optional
// ASCII case folding and whole-word filtering.
// ----------------------------------------------------------------------------
// Feed one line a byte per beat on req_ (tlast on the final byte). Every
// non-overlapping, leftmost-first hit reports its start offset on rsp_; tlast
// marks the last result caused by one input byte (at most two: a held
// whole-word hit resolved by this byte, then a hit ending on it). The block
// takes one byte per clock while req_tready is high: the window compare is a
// combinational AND over a row of byte cells, and the state update closes in
// that same cycle. Each result is queued as its byte is taken and offered on
// rsp_ behind earlier ones; the four-entry queue drops req_tready only while
// it holds more than two, i.e. when the result side stalls, or when a byte
// producing two results arrives while two earlier results still wait. Write
// the csr_ registers only while no line is in flight.
// ----------------------------------------------------------------------------
module whole_word_substring_finder #(
   parameter int PATTERN_MAX = wwsf_pkg::PATTERN_MAX_DEFAULT,
   parameter int LINE_MAX    = wwsf_pkg::LINE_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // text in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] text_byte
   input  logic                            req_tlast,   // line_end
   // results out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [11:0] match_offset, [15:12] zero
   output logic                            rsp_tlast,   // last_of_run
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wwsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wwsf_pkg::CSR_DATA_W-1:0] csr_data
);

   // only the bytes the pattern registers can hold are ever compared
   localparam int LEN_MAX = (PATTERN_MAX < wwsf_pkg::REG_BYTES) ?
                            PATTERN_MAX : wwsf_pkg::REG_BYTES;
   localparam int CELLS   = LEN_MAX;
   localparam int POS_W   = $clog2(LINE_MAX + 1);
   localparam int SUM_W   = POS_W + 1;

   // ---- configuration registers ----
   logic [63:0]                  pattern_low_ff;
   logic [63:0]                  pattern_high_ff;
   logic [wwsf_pkg::LEN_W-1:0]   pattern_length_ff;
   logic                         exact_case_ff;
   logic                         whole_word_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= wwsf_pkg::LEN_W'(1);
         exact_case_ff     <= 1'b0;
         whole_word_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wwsf_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            wwsf_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            wwsf_pkg::CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[wwsf_pkg::LEN_W-1:0];
            wwsf_pkg::CSR_MATCH_CASE:     exact_case_ff     <= csr_data[0];
            wwsf_pkg::CSR_WHOLE_WORD:     whole_word_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   wwsf_pkg::cell_cfg_type cell_cfg;

   always_comb begin
      cell_cfg.pattern = {pattern_high_ff, pattern_low_ff};
      cell_cfg.exact   = exact_case_ff;
      // lengths past what the window holds clamp to the window size
      if (pattern_length_ff > wwsf_pkg::LEN_W'(LEN_MAX)) begin
         cell_cfg.length = wwsf_pkg::LEN_W'(LEN_MAX);
      end else begin
         cell_cfg.length = pattern_length_ff;
      end
   end

   // ---- byte window: chain[k] is the byte k places back, newest included ----
   logic              accept;
   logic [7:0]        chain [CELLS+1];
   logic [CELLS-1:0]  cell_match;

   assign accept   = req_tvalid && req_tready;
   assign chain[0] = req_tdata;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      wwsf_cell #(
         .INDEX (k)
      ) u_cell (
         .clock   (clock),
         .shift   (accept),
         .cfg     (cell_cfg),
         .byte_in (chain[k]),
         .byte_q  (chain[k+1]),
         .match   (cell_match[k])
      );
   end

   // ---- line state ----
   logic [POS_W-1:0]              line_pos_ff, line_pos_in;
   logic [POS_W-1:0]              next_start_ff, next_start_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [wwsf_pkg::OFFSET_W-1:0] pend_start_ff, pend_start_in;

   logic [SUM_W-1:0]              pos_plus1;
   logic [SUM_W-1:0]              len_ext;
   logic [POS_W-1:0]              start;
   logic [7:0]                    prev_byte;
   logic                          cand;
   logic                          hit;
   logic                          emit_pend;
   logic                          emit_new;
   wwsf_pkg::push_type            push0, push1;
   logic                          q_room;
   wwsf_pkg::result_type          q_out;

   always_comb begin
      pos_plus1 = {1'b0, line_pos_ff} + SUM_W'(1);
      len_ext   = SUM_W'(cell_cfg.length);
      start     = POS_W'(pos_plus1 - len_ext);

      // byte just ahead of the candidate (only read when start is nonzero)
      prev_byte = '0;
      for (int k = 0; k <= CELLS; k++) begin
         if (cell_cfg.length == wwsf_pkg::LEN_W'(k)) begin
            prev_byte = chain[k];
         end
      end

      // candidate needs its last byte below LINE_MAX and a full span in line
      cand = (cell_cfg.length != '0) && (line_pos_ff < POS_W'(LINE_MAX)) &&
             (pos_plus1 >= len_ext);
      hit  = cand && (start >= next_start_ff) && (&cell_match);

      // a held whole-word hit is judged on the byte after it
      emit_pend = pend_valid_ff &&
                  !wwsf_pkg::letter(wwsf_pkg::fold(req_tdata, exact_case_ff));

      next_start_in = next_start_ff;
      pend_valid_in = 1'b0;
      pend_start_in = pend_start_ff;
      emit_new      = 1'b0;
      if (hit) begin
         next_start_in = POS_W'(pos_plus1);   // start + length
         if (!whole_word_ff) begin
            emit_new = 1'b1;
         end else if (start != '0 &&
                      wwsf_pkg::letter(wwsf_pkg::fold(prev_byte, exact_case_ff))) begin
            // rejected; span still consumed
         end else if (req_tlast) begin
            emit_new = 1'b1;
         end else begin
            pend_valid_in = 1'b1;
            pend_start_in = wwsf_pkg::OFFSET_W'(start);
         end
      end

      if (req_tlast) begin
         line_pos_in   = '0;
         next_start_in = '0;
         pend_valid_in = 1'b0;
         pend_start_in = '0;
      end else if (line_pos_ff < POS_W'(LINE_MAX)) begin
         line_pos_in = line_pos_ff + POS_W'(1);
      end else begin
         line_pos_in = line_pos_ff;
      end

      // pack results in order: resolved pending hit first
      push0 = '0;
      push1 = '0;
      if (accept) begin
         if (emit_pend) begin
            push0.valid       = 1'b1;
            push0.data.offset = pend_start_ff;
            push0.data.last   = !emit_new;
            push1.valid       = emit_new;
            push1.data.offset = wwsf_pkg::OFFSET_W'(start);
            push1.data.last   = 1'b1;
         end else begin
            push0.valid       = emit_new;
            push0.data.offset = wwsf_pkg::OFFSET_W'(start);
            push0.data.last   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff   <= '0;
         next_start_ff <= '0;
         pend_valid_ff <= 1'b0;
         pend_start_ff <= '0;
      end else if (accept) begin
         line_pos_ff   <= line_pos_in;
         next_start_ff <= next_start_in;
         pend_valid_ff <= pend_valid_in;
         pend_start_ff <= pend_start_in;
      end
   end

   // ---- result queue ----
   wwsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .room      (q_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_out)
   );

   assign req_tready = q_room;
   assign rsp_tdata  = {{(16 - wwsf_pkg::OFFSET_W){1'b0}}, q_out.offset};
   assign rsp_tlast  = q_out.last;

endmodule

// ===== tb/whole_word_substring_finder_tb.sv =====
// ----------------------------------------------------------------------------
// whole_word_substring_finder_tb
// Self-checking bench for the streaming pattern search: lines of text go in a
// beat at a time, every reported match offset is checked against a
// cycle-free model of the search kept inside the bench.
// ----------------------------------------------------------------------------
module whole_word_substring_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_LIMIT  = wwsf_pkg::LINE_MAX_DEFAULT;
   localparam int WINDOW_MAX  =
      (wwsf_pkg::PATTERN_MAX_DEFAULT < wwsf_pkg::REG_BYTES) ?
      wwsf_pkg::PATTERN_MAX_DEFAULT : wwsf_pkg::REG_BYTES;
   localparam int OFFSET_W    = wwsf_pkg::OFFSET_W;
   localparam int REG_BYTES   = wwsf_pkg::REG_BYTES;
   localparam int CSR_IDX_W   = wwsf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = wwsf_pkg::CSR_DATA_W;
   localparam int DRAIN_WAIT  = 16;      // beats of slack after the last result
   localparam int IDLE_PCT    = 16;      // idle / stall rate on both sides
   localparam int HOLD_CYCLES = 300;     // long result-side back-pressure
   localparam int RANDOM_BEATS = 200;
   localparam int LONG_LINE   = 64;      // gapless line length
   localparam int MAX_PRINTS  = 40;

   // index that maps to no register; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd5;

   // byte classes used to build text
   localparam logic [7:0] SPACE = 8'h20;
   localparam logic [7:0] DASH  = 8'h2D;
   localparam logic [7:0] DOT   = 8'h2E;
   // space, comma, dash, the non-letters right next to the letter ranges, and 0x80
   localparam logic [7:0] SEPARATORS [8] = '{8'h20, 8'h2C, 8'h2D, 8'h40,
                                              8'h5B, 8'h60, 8'h7B, 8'h80};

   typedef struct {
      logic [7:0] data;
      logic       eol;
   } text_beat_type;

   typedef struct {
      logic [OFFSET_W-1:0] offset;
      logic                ends_run;
   } match_type;

   // ---------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;   // [7:0] text_byte
   logic                  req_tlast  = 1'b0;    // line_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;            // [11:0] match_offset, [15:12] zero
   logic                  rsp_tlast;            // last_of_run
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   whole_word_substring_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   text_beat_type text_q[$];            // beats waiting for the driver
   match_type     expected_matches[$];  // offsets the block still owes us
   int            mismatch_count = 0;
   int            random_beats   = 0;

   logic req_taken = 1'b0;           // beat on req_ accepted at the last edge
   logic csr_taken = 1'b0;           // csr write accepted at the last edge
   logic no_idle    = 1'b0;          // suppress random gaps on both sides
   logic start_hold = 1'b0;          // ask the result side for one long stall
   logic hold_done  = 1'b0;
   int   hold_left  = 0;

   // copy of the settings for the text generator
   logic [REG_BYTES*8-1:0] gen_pattern;
   int                     gen_len;

   // search model: settings
   logic [63:0] pat_lo;
   logic [63:0] pat_hi;
   logic [4:0]  pat_len;
   logic        exact_case;
   logic        word_mode;
   // search model: line state
   logic [7:0]  window [0:WINDOW_MAX];   // entry 0 is the newest byte
   int unsigned line_pos;
   int unsigned next_start;
   logic        pend_valid;
   int unsigned pend_start;

   match_type     oldest;
   text_beat_type beat;

   // ---------------------------------------------------------------------
   // Queue helpers
   // ---------------------------------------------------------------------
   task automatic add_beat(input logic [7:0] data, input logic eol);
      text_beat_type t;
      t.data = data;
      t.eol  = eol;
      text_q.insert(text_q.size(), t);
   endtask

   task automatic add_match(input logic [OFFSET_W-1:0] offset);
      match_type m;
      m.offset   = offset;
      m.ends_run = 1'b0;
      expected_matches.insert(expected_matches.size(), m);
   endtask

   // ---------------------------------------------------------------------
   // Search model
   // ---------------------------------------------------------------------
   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      if (!exact_case && (c inside {[8'h41:8'h5A]})) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // bytes that count as part of a word for the border test
   function automatic logic word_byte(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F}) || c > 8'h80;
   endfunction

   task automatic search_reset();
      pat_lo     = '0;
      pat_hi     = '0;
      pat_len    = 5'd1;
      exact_case = 1'b0;
      word_mode  = 1'b0;
      window     = '{default: 8'h00};
      line_pos   = 0;
      next_start = 0;
      pend_valid = 1'b0;
      pend_start = 0;
   endtask

   task automatic search_config(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      case (idx)
         wwsf_pkg::CSR_PATTERN_LOW:    pat_lo = value;
         wwsf_pkg::CSR_PATTERN_HIGH:   pat_hi = value;
         wwsf_pkg::CSR_PATTERN_LENGTH: pat_len = value[4:0];
         wwsf_pkg::CSR_MATCH_CASE:     exact_case = value[0];
         wwsf_pkg::CSR_WHOLE_WORD:     word_mode = value[0];
         default: ;
      endcase
   endtask

   // One text byte in; appends the offsets it reports to expected_matches.
   task automatic predict_matches(input logic [7:0] b, input logic eol);
      logic [REG_BYTES*8-1:0] pattern_bits;
      int unsigned            len;
      int unsigned            start;
      int unsigned            i;
      int                     found;
      logic                   hit;

      pattern_bits = {pat_hi, pat_lo};
      len   = (pat_len > WINDOW_MAX) ? WINDOW_MAX : pat_len;
      found = 0;

      // a held whole-word hit is settled by the byte that follows it
      if (pend_valid) begin
         pend_valid = 1'b0;
         if (!word_byte(fold_byte(b))) begin
            add_match(pend_start[OFFSET_W-1:0]);
            found++;
         end
      end

      for (i = WINDOW_MAX; i > 0; i--) begin
         window[i] = window[i-1];
      end
      window[0] = b;

      // only candidates whose last byte is inside the position limit
      if (len > 0 && line_pos < LINE_LIMIT && line_pos + 1 >= len) begin
         start = line_pos + 1 - len;
         hit   = start >= next_start;
         for (i = 0; hit && i < len; i++) begin
            if (fold_byte(window[len-1-i]) != fold_byte(pattern_bits[8*i +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            // span is consumed even if the border test throws it out
            next_start = start + len;
            if (!word_mode || eol) begin
               // at line end only the leading border can reject it
               if (!word_mode || start == 0 || !word_byte(fold_byte(window[len]))) begin
                  add_match(start[OFFSET_W-1:0]);
                  found++;
               end
            end else if (start == 0 || !word_byte(fold_byte(window[len]))) begin
               pend_valid = 1'b1;
               pend_start = start;
            end
         end
      end

      if (eol) begin
         line_pos   = 0;
         next_start = 0;
         pend_valid = 1'b0;
         pend_start = 0;
         window     = '{default: 8'h00};
      end else if (line_pos < LINE_LIMIT) begin
         line_pos++;
      end

      if (found > 0) begin
         expected_matches[expected_matches.size()-1].ends_run = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTS) begin
         $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: everything happens on the rising edge. Outputs seen here are
   // the pre-edge values, so a result can never belong to the beat that is
   // accepted on this same edge; checking before predicting is safe.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
         search_reset();
      end else begin
         req_taken <= req_tvalid && req_tready;
         csr_taken <= csr_valid && csr_ready;

         if (csr_valid && csr_ready) begin
            search_config(csr_index, csr_data);
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch("result with nothing outstanding", 32'(rsp_tdata), '0);
            end else begin
               oldest = expected_matches.pop_front();
               if (rsp_tdata !== {{(16-OFFSET_W){1'b0}}, oldest.offset}) begin
                  report_mismatch("match_offset", 32'(rsp_tdata), 32'(oldest.offset));
               end
               if (rsp_tlast !== oldest.ends_run) begin
                  report_mismatch("last_of_run", 32'(rsp_tlast), 32'(oldest.ends_run));
               end
            end
         end

         if (req_tvalid && req_tready) begin
            predict_matches(req_tdata, req_tlast);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Text driver: falling edge. A beat stays up until taken; gaps only
   // open between beats.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (text_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
            beat = text_q.pop_front();
            req_tdata  <= beat.data;
            req_tlast  <= beat.eol;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off counted here so the
   // internal queue fills and req_tready has to drop.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (start_hold && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // caller sits on a falling edge; returns on the falling edge after the
   // write was taken so the next one can go straight out
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_taken);
   endtask

   task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len, input logic exact,
                               input logic word);
      @(negedge clock);
      csr_write(wwsf_pkg::CSR_PATTERN_LOW, lo);
      csr_write(wwsf_pkg::CSR_PATTERN_HIGH, hi);
      csr_write(wwsf_pkg::CSR_PATTERN_LENGTH, {59'd0, len});
      csr_write(wwsf_pkg::CSR_MATCH_CASE, {63'd0, exact});
      csr_write(wwsf_pkg::CSR_WHOLE_WORD, {63'd0, word});
      csr_valid <= 1'b0;
      @(posedge clock);
      gen_pattern = {hi, lo};
      gen_len     = (len > WINDOW_MAX) ? WINDOW_MAX : len;
   endtask

   task automatic queue_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) begin
         add_beat(s[k], k == s.len() - 1);
      end
   endtask

   // Well-formed text: mostly pattern copies (case randomly flipped) between
   // separators and word bytes, with some fully random bytes mixed in.
   task automatic queue_random_line(input int n);
      int         k;
      int         pat_idx;
      logic [7:0] c;
      pat_idx = gen_len;
      for (k = 0; k < n; k++) begin
         if (pat_idx >= gen_len && gen_len != 0 && $urandom_range(9) < 4) begin
            pat_idx = 0;
         end
         if (pat_idx < gen_len) begin
            c = gen_pattern[8*pat_idx +: 8];
            pat_idx++;
            if ((c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) && $urandom_range(2) == 0) begin
               c = c ^ 8'h20;
            end
         end else begin
            case ($urandom_range(5))
               0, 1: c = SEPARATORS[3'($urandom_range(7))];
               2, 3: begin
                  case ($urandom_range(3))
                     0: c = 8'("a" + $urandom_range(25));
                     1: c = 8'("A" + $urandom_range(25));
                     2: c = "_";
                     default: c = 8'($urandom_range(255, 129));
                  endcase
               end
               default: c = 8'($urandom_range(255));
            endcase
         end
         add_beat(c, k == n - 1);
      end
      random_beats += n;
   endtask

   task automatic random_config();
      logic [REG_BYTES*8-1:0] pat;
      logic [4:0]             len;
      logic                   letters;
      int                     j;
      letters = $urandom_range(3) != 0;
      for (j = 0; j < REG_BYTES; j++) begin
         if (!letters) begin
            pat[8*j +: 8] = 8'($urandom_range(255));
         end else if ($urandom_range(9) == 0) begin
            pat[8*j +: 8] = DASH;
         end else begin
            pat[8*j +: 8] = ($urandom_range(2) == 0) ? 8'("A" + $urandom_range(25))
                                                     : 8'("a" + $urandom_range(25));
         end
      end
      // zero length (never matches) and oversize (clamped) show up now and then
      case ($urandom_range(19))
         0:       len = 5'd0;
         1:       len = 5'($urandom_range(31, 17));
         2, 3:    len = 5'd16;
         default: len = 5'($urandom_range(4, 1));
      endcase
      apply_config(pat[63:0], pat[127:64], len, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
   endtask

   // Until every beat is in and every result out, then a few more beats of
   // slack since a beat may still be in flight without owing a result.
   task automatic wait_idle();
      int guard;
      guard = 0;
      while ((text_q.size() != 0 || req_tvalid || expected_matches.size() != 0) &&
             guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_WAIT) @(negedge clock);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int         k;
      int         lines;
      logic [7:0] c;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a write to an unmapped index, then whole-word search for "cat", case folded
      @(negedge clock);
      csr_write(CSR_SPARE, '1);
      csr_valid <= 1'b0;
      @(posedge clock);
      apply_config(64'h0000_0000_0074_6163, 64'h0, 5'd3, 1'b0, 1'b1);
      queue_text("CAT");         // whole line is the hit; upper case folds
      queue_text(" cat cats");   // held hit accepted by space, then one killed by 's'
      queue_text("xcat");        // hit on the last byte, killed by its leading 'x'
      wait_idle();

      // "-" exact, whole word: one byte resolves a held hit and makes a new one
      apply_config(64'h0000_0000_0000_002D, 64'h0, 5'd1, 1'b1, 1'b1);
      queue_text("-- ");
      queue_text("_--\x80");     // '_' borders the first; 0x80 is not a letter
      wait_idle();

      // back-pressure: a hit on every byte while the result side holds off
      start_hold = 1'b1;
      apply_config({56'd0, DOT}, 64'h0, 5'd1, 1'b1, 1'b0);
      add_beat(SPACE, 1'b0);
      for (k = 0; k < 80; k++) begin
         add_beat(DOT, k == 79);
      end
      wait_idle();

      // random settings, a few random lines each
      while (random_beats < RANDOM_BEATS) begin
         random_config();
         lines = $urandom_range(5, 2);
         repeat (lines) queue_random_line($urandom_range(gen_len + 24, 1));
         wait_idle();
      end

      // one line with no gaps on either side: "ab" in a mix of a, b, B, space
      no_idle = 1'b1;
      apply_config(64'h0000_0000_0000_6261, 64'h0, 5'd2, 1'b0, 1'b0);
      for (k = 0; k < LONG_LINE; k++) begin
         case ($urandom_range(3))
            0:       c = "a";
            1:       c = "b";
            2:       c = "B";
            default: c = SPACE;
         endcase
         add_beat(c, k == LONG_LINE - 1);
      end
      wait_idle();

      if (expected_matches.size() != 0) begin
         report_mismatch("results never delivered", expected_matches.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/wwsf_pkg.sv
sv/wwsf_cell.sv
sv/wwsf_queue.sv
sv/whole_word_substring_finder.sv
tb/whole_word_substring_finder_tb.sv
